>>> sv/rtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rtq_pkg: shared types and constants
// Payload structs, case codes and the output clamp for the matrix-to-
// quaternion pipeline.
// ---------------------------------------------------------------------------
package rtq_pkg;

    localparam int DATA_WIDTH    = 16;
    localparam int FRAC_BITS_DEF = 14;

    // which case feeds the output mapping
    localparam logic [1:0] SEL_AX0   = 2'd0;
    localparam logic [1:0] SEL_AX1   = 2'd1;
    localparam logic [1:0] SEL_AX2   = 2'd2;
    localparam logic [1:0] SEL_TRACE = 2'd3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] r0c0;
        logic signed [DATA_WIDTH-1:0] r0c1;
        logic signed [DATA_WIDTH-1:0] r0c2;
        logic signed [DATA_WIDTH-1:0] r1c0;
        logic signed [DATA_WIDTH-1:0] r1c1;
        logic signed [DATA_WIDTH-1:0] r1c2;
        logic signed [DATA_WIDTH-1:0] r2c0;
        logic signed [DATA_WIDTH-1:0] r2c1;
        logic signed [DATA_WIDTH-1:0] r2c2;
    } t_mat;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quat_w;
        logic signed [DATA_WIDTH-1:0] quat_x;
        logic signed [DATA_WIDTH-1:0] quat_y;
        logic signed [DATA_WIDTH-1:0] quat_z;
    } t_quat;

    // clamp a magnitude with sign to the signed output range
    function automatic logic [DATA_WIDTH-1:0] sat_out(input logic [63:0] mag,
                                                      input logic neg);
        logic [63:0] pmax;
        logic [63:0] m;
        begin
            pmax = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
            if (!neg) begin
                m = (mag > pmax) ? pmax : mag;
                sat_out = m[DATA_WIDTH-1:0];
            end else begin
                m = (mag > pmax + 64'd1) ? pmax + 64'd1 : mag;
                sat_out = DATA_WIDTH'(64'd0 - m);
            end
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
`default_nettype none
// Stages at the defaults: 1 set-up register, 16 root cells, 31 division cells,
//   1 output register.
// Throughput: one matrix per cycle; the cell chain advances whenever the
//   output register is empty or being taken, so a stall halts the whole chain.
// Reset: synchronous, active low; clears every valid flag, data is left as is.
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion: rotation matrix to unit quaternion
// Set-up stage, a chain of square-root cells, a chain of three-lane divider
// cells, then clamping and output mapping.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rtq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_mat i_mat,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_quat     o_quat
);
    localparam int DW   = DATA_WIDTH;
    localparam int RTW  = (DW + 3 + FRAC_BITS) / 2;
    localparam int SW   = 2 * RTW;
    localparam int MW   = DW + 1;
    localparam int QW   = MW + FRAC_BITS;
    localparam int DVW  = RTW + 1;
    localparam int STAG = 3 * MW + 3 + 2;
    localparam int DTAG = RTW + 3 + 2;

    logic adv;

    logic            p_valid;
    logic [SW-1:0]   p_rad;
    logic [3*MW-1:0] p_mag;
    logic [2:0]      p_neg;
    logic [1:0]      p_sel;

    // root chain
    logic             s_valid [RTW+1];
    logic [SW-1:0]    s_rad   [RTW+1];
    logic [RTW+1:0]   s_rem   [RTW+1];
    logic [RTW-1:0]   s_root  [RTW+1];
    logic [STAG-1:0]  s_tag   [RTW+1];

    // division chain
    logic             d_valid [QW+1];
    logic [DVW-1:0]   d_dv    [QW+1];
    logic [3*DVW-1:0] d_rem   [QW+1];
    logic [3*QW-1:0]  d_dq    [QW+1];
    logic [DTAG-1:0]  d_tag   [QW+1];

    logic [3*MW-1:0]  sq_mag;
    logic [RTW-1:0]   f_root;
    logic [2:0]       f_neg;
    logic [1:0]       f_sel;
    logic [DW-1:0]    half;
    logic [DW-1:0]    qv [3];
    t_quat            n_quat;
    t_quat            r_quat;
    logic             r_valid;

    assign adv     = !r_valid || !i_stall;
    assign o_stall = !adv;

    rtq_prep #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_mat   (i_mat),
        .o_valid (p_valid),
        .o_rad   (p_rad),
        .o_mag   (p_mag),
        .o_neg   (p_neg),
        .o_sel   (p_sel)
    );

    assign s_valid[0] = p_valid;
    assign s_rad[0]   = p_rad;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_tag[0]   = {p_mag, p_neg, p_sel};

    for (genvar g = 0; g < RTW; g++) begin : g_sqrt
        rtq_sqrt_cell #(.RTW(RTW), .TAG_W(STAG)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (s_valid[g]),
            .i_rad   (s_rad[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_tag   (s_tag[g]),
            .o_valid (s_valid[g+1]),
            .o_rad   (s_rad[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_tag   (s_tag[g+1])
        );
    end

    assign sq_mag     = s_tag[RTW][STAG-1 -: 3*MW];
    assign d_valid[0] = s_valid[RTW];
    assign d_dv[0]    = {s_root[RTW], 1'b0};
    assign d_rem[0]   = '0;
    assign d_tag[0]   = {s_root[RTW], s_tag[RTW][4:0]};
    for (genvar k = 0; k < 3; k++) begin : g_load
        assign d_dq[0][k*QW +: QW] = QW'(sq_mag[k*MW +: MW]) << FRAC_BITS;
    end

    for (genvar g = 0; g < QW; g++) begin : g_div
        rtq_div_cell #(.QW(QW), .DVW(DVW), .TAG_W(DTAG)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (d_valid[g]),
            .i_dv    (d_dv[g]),
            .i_rem   (d_rem[g]),
            .i_dq    (d_dq[g]),
            .i_tag   (d_tag[g]),
            .o_valid (d_valid[g+1]),
            .o_dv    (d_dv[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_dq    (d_dq[g+1]),
            .o_tag   (d_tag[g+1])
        );
    end

    always_comb begin
        f_root = d_tag[QW][DTAG-1 -: RTW];
        f_neg  = d_tag[QW][4:2];
        f_sel  = d_tag[QW][1:0];
        half   = sat_out(64'(f_root >> 1), 1'b0);
        for (int k = 0; k < 3; k++) begin
            // zero root: skip the division result
            qv[k] = (f_root == '0) ? '0 : sat_out(64'(d_dq[QW][k*QW +: QW]), f_neg[k]);
        end
        n_quat = '0;
        case (f_sel)
            SEL_TRACE: begin
                n_quat.quat_w = half;  n_quat.quat_x = qv[0];
                n_quat.quat_y = qv[1]; n_quat.quat_z = qv[2];
            end
            SEL_AX0: begin
                n_quat.quat_w = qv[0]; n_quat.quat_x = half;
                n_quat.quat_y = qv[1]; n_quat.quat_z = qv[2];
            end
            SEL_AX1: begin
                n_quat.quat_w = qv[0]; n_quat.quat_y = half;
                n_quat.quat_z = qv[1]; n_quat.quat_x = qv[2];
            end
            default: begin
                n_quat.quat_w = qv[0]; n_quat.quat_z = half;
                n_quat.quat_x = qv[1]; n_quat.quat_y = qv[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= d_valid[QW];
        end
        if (adv) begin
            r_quat <= n_quat;
        end
    end

    assign o_valid = r_valid;
    assign o_quat  = r_quat;

    a_stall_ties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (r_valid && i_stall))
        else $error("input stall does not follow output stall");
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(p_valid) && $stable(d_valid[QW]))
        else $error("cell chain moved during a stall");
endmodule
`default_nettype wire

>>> sv/rtq_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rtq_prep: case selection and operand set-up
// Picks the trace or largest-diagonal case, forms the radicand and the three
// numerators, and registers them for the root chain.
// ---------------------------------------------------------------------------
module rtq_prep
    import rtq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SW        = 2 * ((DATA_WIDTH + 3 + FRAC_BITS) / 2)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire t_mat                  i_mat,
    output logic                       o_valid,
    output logic [SW-1:0]              o_rad,
    output logic [3*(DATA_WIDTH+1)-1:0] o_mag,
    output logic [2:0]                 o_neg,
    output logic [1:0]                 o_sel
);
    localparam int DW = DATA_WIDTH;
    localparam int RW = DW + 3;

    logic signed [DW-1:0]   e [3][3];
    logic signed [RW-1:0]   dsum, rad, one;
    logic signed [RW-1:0]   daa, dbb, dcc;
    logic signed [DW:0]     num [3];
    logic [1:0]             sel;
    logic [1:0]             ax;

    logic                   r_valid;
    logic [SW-1:0]          r_rad;
    logic [3*(DW+1)-1:0]    r_mag;
    logic [2:0]             r_neg;
    logic [1:0]             r_sel;
    logic [SW-1:0]          n_rad;
    logic [3*(DW+1)-1:0]    n_mag;
    logic [2:0]             n_neg;

    always_comb begin
        e[0][0] = i_mat.r0c0; e[0][1] = i_mat.r0c1; e[0][2] = i_mat.r0c2;
        e[1][0] = i_mat.r1c0; e[1][1] = i_mat.r1c1; e[1][2] = i_mat.r1c2;
        e[2][0] = i_mat.r2c0; e[2][1] = i_mat.r2c1; e[2][2] = i_mat.r2c2;
        one  = RW'(1) << FRAC_BITS;
        dsum = RW'(e[0][0]) + RW'(e[1][1]) + RW'(e[2][2]);
        ax = SEL_AX0;
        if (e[1][1] > e[0][0]) ax = SEL_AX1;
        if (e[2][2] > e[ax][ax]) ax = SEL_AX2;
        sel = (dsum > 0) ? SEL_TRACE : ax;
        daa = '0; dbb = '0; dcc = '0;
        case (sel)
            SEL_TRACE: begin
                num[0] = (DW+1)'(e[2][1]) - (DW+1)'(e[1][2]);
                num[1] = (DW+1)'(e[0][2]) - (DW+1)'(e[2][0]);
                num[2] = (DW+1)'(e[1][0]) - (DW+1)'(e[0][1]);
            end
            SEL_AX0: begin
                daa = RW'(e[0][0]); dbb = RW'(e[1][1]); dcc = RW'(e[2][2]);
                num[0] = (DW+1)'(e[2][1]) - (DW+1)'(e[1][2]);
                num[1] = (DW+1)'(e[1][0]) + (DW+1)'(e[0][1]);
                num[2] = (DW+1)'(e[2][0]) + (DW+1)'(e[0][2]);
            end
            SEL_AX1: begin
                daa = RW'(e[1][1]); dbb = RW'(e[2][2]); dcc = RW'(e[0][0]);
                num[0] = (DW+1)'(e[0][2]) - (DW+1)'(e[2][0]);
                num[1] = (DW+1)'(e[2][1]) + (DW+1)'(e[1][2]);
                num[2] = (DW+1)'(e[0][1]) + (DW+1)'(e[1][0]);
            end
            default: begin
                daa = RW'(e[2][2]); dbb = RW'(e[0][0]); dcc = RW'(e[1][1]);
                num[0] = (DW+1)'(e[1][0]) - (DW+1)'(e[0][1]);
                num[1] = (DW+1)'(e[0][2]) + (DW+1)'(e[2][0]);
                num[2] = (DW+1)'(e[1][2]) + (DW+1)'(e[2][1]);
            end
        endcase
        rad = (sel == SEL_TRACE) ? dsum + one : daa - (dbb + dcc) + one;
        // non-positive radicand gives a zero root
        n_rad = (rad > 0) ? (SW'(rad[RW-2:0]) << FRAC_BITS) : '0;
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = num[k][DW];
            n_mag[k*(DW+1) +: DW+1] = num[k][DW] ? (DW+1)'(-num[k]) : num[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_rad <= n_rad;
            r_mag <= n_mag;
            r_neg <= n_neg;
            r_sel <= sel;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;
    assign o_sel   = r_sel;
endmodule
`default_nettype wire

>>> sv/rtq_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rtq_sqrt_cell: one restoring square-root step
// Brings down two radicand bits, resolves one root bit, passes a side tag.
// ---------------------------------------------------------------------------
module rtq_sqrt_cell
    import rtq_pkg::*;
#(
    parameter int RTW   = 16,
    parameter int TAG_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [2*RTW-1:0]  i_rad,
    input  wire logic [RTW+1:0]    i_rem,
    input  wire logic [RTW-1:0]    i_root,
    input  wire logic [TAG_W-1:0]  i_tag,
    output logic                   o_valid,
    output logic [2*RTW-1:0]       o_rad,
    output logic [RTW+1:0]         o_rem,
    output logic [RTW-1:0]         o_root,
    output logic [TAG_W-1:0]       o_tag
);
    logic [RTW+1:0]   rs, tr;
    logic             ge;
    logic             r_valid;
    logic [2*RTW-1:0] r_rad;
    logic [RTW+1:0]   r_rem;
    logic [RTW-1:0]   r_root;
    logic [TAG_W-1:0] r_tag;
    logic [RTW+1:0]   n_rem;
    logic [RTW-1:0]   n_root;

    always_comb begin
        rs     = {i_rem[RTW-1:0], i_rad[2*RTW-1 -: 2]};
        tr     = {i_root, 2'b01};
        ge     = (rs >= tr);
        n_rem  = ge ? rs - tr : rs;
        n_root = {i_root[RTW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_rad  <= i_rad << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_tag  <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_tag   = r_tag;
endmodule
`default_nettype wire

>>> sv/rtq_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rtq_div_cell: one restoring division step on three lanes
// Each lane shifts one dividend bit into its remainder and one quotient bit
// into the freed low end; the divisor and side tag travel alongside.
// ---------------------------------------------------------------------------
module rtq_div_cell
    import rtq_pkg::*;
#(
    parameter int QW    = 31,
    parameter int DVW   = 17,
    parameter int TAG_W = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [DVW-1:0]     i_dv,
    input  wire logic [3*DVW-1:0]   i_rem,
    input  wire logic [3*QW-1:0]    i_dq,
    input  wire logic [TAG_W-1:0]   i_tag,
    output logic                    o_valid,
    output logic [DVW-1:0]          o_dv,
    output logic [3*DVW-1:0]        o_rem,
    output logic [3*QW-1:0]         o_dq,
    output logic [TAG_W-1:0]        o_tag
);
    logic [DVW:0]     rs;
    logic             ge;
    logic             r_valid;
    logic [DVW-1:0]   r_dv;
    logic [3*DVW-1:0] r_rem;
    logic [3*QW-1:0]  r_dq;
    logic [TAG_W-1:0] r_tag;
    logic [3*DVW-1:0] n_rem;
    logic [3*QW-1:0]  n_dq;

    always_comb begin
        n_rem = '0;
        n_dq  = '0;
        for (int k = 0; k < 3; k++) begin
            rs = {i_rem[k*DVW +: DVW], i_dq[k*QW + QW - 1]};
            ge = (rs >= {1'b0, i_dv});
            n_rem[k*DVW +: DVW] = ge ? DVW'(rs - {1'b0, i_dv}) : DVW'(rs);
            n_dq[k*QW +: QW]    = {i_dq[k*QW +: QW-1], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_dv  <= i_dv;
            r_rem <= n_rem;
            r_dq  <= n_dq;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_dv    = r_dv;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_tag   = r_tag;
endmodule
`default_nettype wire

>>> tb/rtq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtq_checker: quaternion predictor and scoreboard
// Watches both channels, computes the expected quaternion for every matrix
// transfer and compares each output transfer against the oldest one.
// ---------------------------------------------------------------------------
module rtq_checker
    import rtq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_stall_in,
    input  wire t_mat i_mat,
    input  wire logic i_out_valid,
    input  wire logic i_out_stall,
    input  wire t_quat i_quat,
    output int        o_errors,
    output int        o_pending
);

    localparam int FB = FRAC_BITS_DEF;

    t_quat quat_q[$];
    int    errors = 0;

    assign o_errors  = errors;
    assign o_pending = quat_q.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] clamp(input logic [63:0] mag,
                                                    input logic neg);
        logic [63:0] pmax;
        pmax = (64'd1 << (DATA_WIDTH - 1)) - 1;
        if (!neg) return (mag > pmax) ? pmax[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
        if (mag > pmax + 1) mag = pmax + 1;
        return DATA_WIDTH'(64'd0 - mag);
    endfunction

    function automatic logic [63:0] root_from(input longint rad);
        if (rad <= 0) return 0;
        return int_sqrt(64'(rad) << FB);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] div_root(input longint num,
                                                       input logic [63:0] root);
        logic [63:0] mag;
        if (root == 0) return '0;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        return clamp((mag << FB) / (2 * root), num < 0);
    endfunction

    function automatic t_quat predict_quat(input t_mat m);
        longint e[3][3];
        longint one;
        longint dsum;
        logic [63:0] root;
        logic [DATA_WIDTH-1:0] part[3];
        int ax, bx, cx;
        t_quat q;
        one = 64'sd1 << FB;
        e[0][0] = m.r0c0; e[0][1] = m.r0c1; e[0][2] = m.r0c2;
        e[1][0] = m.r1c0; e[1][1] = m.r1c1; e[1][2] = m.r1c2;
        e[2][0] = m.r2c0; e[2][1] = m.r2c1; e[2][2] = m.r2c2;
        dsum = e[0][0] + e[1][1] + e[2][2];
        if (dsum > 0) begin
            root     = root_from(dsum + one);
            q.quat_w = clamp(root >> 1, 1'b0);
            q.quat_x = div_root(e[2][1] - e[1][2], root);
            q.quat_y = div_root(e[0][2] - e[2][0], root);
            q.quat_z = div_root(e[1][0] - e[0][1], root);
        end else begin
            ax = 0;
            if (e[1][1] > e[0][0]) ax = 1;
            if (e[2][2] > e[ax][ax]) ax = 2;
            bx = (ax + 1) % 3;
            cx = (bx + 1) % 3;
            root     = root_from(e[ax][ax] - (e[bx][bx] + e[cx][cx]) + one);
            part[ax] = clamp(root >> 1, 1'b0);
            q.quat_w = div_root(e[cx][bx] - e[bx][cx], root);
            part[bx] = div_root(e[bx][ax] + e[ax][bx], root);
            part[cx] = div_root(e[cx][ax] + e[ax][cx], root);
            q.quat_x = part[0];
            q.quat_y = part[1];
            q.quat_z = part[2];
        end
        return q;
    endfunction

    task automatic report(input string what, input logic [15:0] got,
                          input logic [15:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_quat want;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in) quat_q.push_back(predict_quat(i_mat));
            if (i_out_valid && !i_out_stall) begin
                if (quat_q.size() == 0) begin
                    $display("unexpected output transfer %h", i_quat);
                    errors++;
                end else begin
                    want = quat_q.pop_front();
                    if (i_quat.quat_w !== want.quat_w) report("w", i_quat.quat_w, want.quat_w);
                    if (i_quat.quat_x !== want.quat_x) report("x", i_quat.quat_x, want.quat_x);
                    if (i_quat.quat_y !== want.quat_y) report("y", i_quat.quat_y, want.quat_y);
                    if (i_quat.quat_z !== want.quat_z) report("z", i_quat.quat_z, want.quat_z);
                end
            end
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: matrix-to-quaternion pipeline test
// Directed corner matrices, then mostly near-rotation matrices with random
// noise, with random gaps on the input and random stalls on the output.
// ---------------------------------------------------------------------------
module testbench;
    import rtq_pkg::*;

    localparam int                 N_RANDOM = 1750;
    localparam logic signed [15:0] ONE      = 16'sd16384;

    logic  i_clk = 0;
    logic  i_rst_n = 0;
    logic  i_valid = 0;
    logic  o_stall;
    t_mat  i_mat = '0;
    logic  o_valid;
    logic  i_stall = 0;
    t_quat o_quat;
    int    errors;
    int    pending;
    bit    sending_done = 0;

    always #1 i_clk = ~i_clk;

    rotation_matrix_to_quaternion dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mat, .o_valid, .i_stall, .o_quat
    );

    rtq_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_mat,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_quat(o_quat),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic t_mat diag_mat(input int a, input int b, input int c);
        t_mat m;
        m = '0;
        m.r0c0 = 16'(a); m.r1c1 = 16'(b); m.r2c2 = 16'(c);
        return m;
    endfunction

    function automatic t_mat rand_mat();
        t_mat m;
        int k;
        int noise;
        k = $urandom_range(0, 9);
        if (k < 2) return t_mat'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        // signed permutation of identity with noise of up to 64 or 4096: reaches every axis case
        m = '0;
        noise = (k < 6) ? 64 : 4096;
        case ($urandom_range(0, 5))
            0: begin m.r0c0 = ONE; m.r1c1 = ONE; m.r2c2 = ONE; end
            1: begin m.r0c0 = ONE; m.r1c1 = -ONE; m.r2c2 = -ONE; end
            2: begin m.r0c0 = -ONE; m.r1c1 = ONE; m.r2c2 = -ONE; end
            3: begin m.r0c0 = -ONE; m.r1c1 = -ONE; m.r2c2 = ONE; end
            4: begin m.r0c1 = ONE; m.r1c0 = -ONE; m.r2c2 = ONE; end
            default: begin m.r0c2 = ONE; m.r1c1 = ONE; m.r2c0 = -ONE; end
        endcase
        m.r0c0 += 16'($urandom_range(0, 2 * noise) - noise);
        m.r0c1 += 16'($urandom_range(0, 2 * noise) - noise);
        m.r0c2 += 16'($urandom_range(0, 2 * noise) - noise);
        m.r1c0 += 16'($urandom_range(0, 2 * noise) - noise);
        m.r1c1 += 16'($urandom_range(0, 2 * noise) - noise);
        m.r1c2 += 16'($urandom_range(0, 2 * noise) - noise);
        m.r2c0 += 16'($urandom_range(0, 2 * noise) - noise);
        m.r2c1 += 16'($urandom_range(0, 2 * noise) - noise);
        m.r2c2 += 16'($urandom_range(0, 2 * noise) - noise);
        return m;
    endfunction

    task automatic send_mat(input t_mat m);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_mat   <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // receiver: hold stall for a random number of cycles per transfer
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (hold != 0) begin
                i_stall <= 1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        t_mat m;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_mat(diag_mat(ONE, ONE, ONE));
        send_mat(diag_mat(ONE, -ONE, -ONE));
        send_mat(diag_mat(-ONE, ONE, -ONE));
        send_mat(diag_mat(-ONE, -ONE, ONE));
        send_mat(diag_mat(0, 0, 0));
        send_mat(diag_mat(-ONE, -ONE, -ONE));
        send_mat(diag_mat(5000, 5000, 5000));
        send_mat(diag_mat(-32768, -32768, -32768));
        send_mat(diag_mat(32767, 32767, 32767));
        send_mat(diag_mat(-16384, 0, 0));
        send_mat(diag_mat(0, 0, -ONE));
        send_mat(t_mat'({9{16'h8000}}));
        send_mat(t_mat'({9{16'h7fff}}));
        send_mat(t_mat'({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                         16'h8000, 16'h7fff, 16'h8000, 16'h7fff}));
        send_mat(t_mat'({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                         16'h7fff, 16'h8000, 16'h7fff, 16'h8000}));
        m = diag_mat(-ONE, -ONE, -ONE);
        m.r0c1 = 16'sh7fff; m.r1c0 = 16'sh7fff; m.r0c2 = 16'sh8000; m.r2c0 = 16'sh8000;
        send_mat(m);
        send_mat(t_mat'('1));
        for (int n = 0; n < N_RANDOM; n++) send_mat(rand_mat());
        i_valid <= 0;
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("rotation_matrix_to_quaternion verification clean");
        else
            $display("rotation_matrix_to_quaternion verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("rotation_matrix_to_quaternion verification failed");
        $finish;
    end

endmodule
